FILE: rtl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types for the sparse set membership block: request opcodes and
// controller states.
// ----------------------------------------------------------------------------
package ssm_pkg;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_ERASE    = 3'd1,
        OP_CONTAINS = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_READ     = 3'd4
    } op_t;

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_LOOK   = 8'b0000_0100,
        ST_EVAL   = 8'b0000_1000,
        ST_CHECK  = 8'b0001_0000,
        ST_ERASE2 = 8'b0010_0000,
        ST_CLR    = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

endpackage

FILE: rtl/ssm_ram.sv
// ----------------------------------------------------------------------------
// ssm_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read (old data on a same-address collision).
// ----------------------------------------------------------------------------
module ssm_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 11
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sparse_set_membership.sv
// ----------------------------------------------------------------------------
// sparse_set_membership
// Sparse set of generational handles held in two synchronous RAMs.
// ----------------------------------------------------------------------------
// Usage: the block keeps a set of handles (slot index plus generation). A
// position table, addressed by slot index, holds a present flag and the dense
// position of the handle; a member RAM, addressed by dense position, holds the
// handle itself. Both RAMs have one write and one registered read port, and
// one request is worked on at a time by a small sequencer that reads, checks
// and writes back. Insert, read, unused op codes, and erase or contains of an
// absent index pass through the look, evaluate and done states; erase and
// contains of a present index also pass through ERASE2 or CHECK (erase writes
// the position table twice, contains follows the table into the member RAM);
// clear goes from look to the clear state, which for a non-empty set walks the
// dense entries and drops each one from the position table. A new request is
// taken in the idle state that follows the load of the result register; the
// result register lets the next request in while the previous result still
// waits, and only a result that is still unaccepted when the next one is
// ready holds the sequencer. After reset the position table is swept to
// all-absent, one entry per cycle over all 2^INDEX_BITS entries (1024 by
// default); s_ready stays low until it is done.
// ----------------------------------------------------------------------------
module sparse_set_membership
    import ssm_pkg::*;
#(
    parameter int INDEX_BITS = 10,
    parameter int GEN_BITS   = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_op,
    input  logic [INDEX_BITS-1:0] s_entity_index,
    input  logic [GEN_BITS-1:0]   s_entity_generation,
    input  logic [INDEX_BITS-1:0] s_dense_position,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [INDEX_BITS-1:0] m_slot_position,
    output logic [INDEX_BITS-1:0] m_entry_index,
    output logic [GEN_BITS-1:0]   m_entry_generation,
    output logic [INDEX_BITS:0]   m_member_count
);

    localparam int IB     = INDEX_BITS;
    localparam int POS_W  = IB + 1;          // present flag + dense position
    localparam int MEM_W  = IB + GEN_BITS;   // slot index + generation

    // controller state
    state_t          state_reg, state_next;
    logic [IB-1:0]   init_reg, init_next;   // reset sweep address
    logic [IB:0]     count_reg, count_next;
    logic [IB:0]     walk_reg, walk_next;   // clear walk position
    logic            pend_reg, pend_next;   // clear walk read in flight
    logic            m_valid_reg, m_valid_next;

    // request and working payload
    op_t             op_reg, op_next;
    logic [IB-1:0]   idx_reg, idx_next;
    logic [GEN_BITS-1:0] gen_reg, gen_next;
    logic [IB-1:0]   dpos_reg, dpos_next;
    logic [IB-1:0]   p_reg, p_next;

    // pending result
    logic            hit_reg, hit_next;
    logic [IB-1:0]   slot_reg, slot_next;
    logic [IB-1:0]   eidx_reg, eidx_next;
    logic [GEN_BITS-1:0] egen_reg, egen_next;

    // result register
    logic            m_hit_reg, m_hit_next;
    logic [IB-1:0]   m_slot_reg, m_slot_next;
    logic [IB-1:0]   m_eidx_reg, m_eidx_next;
    logic [GEN_BITS-1:0] m_egen_reg, m_egen_next;
    logic [IB:0]     m_count_reg, m_count_next;

    // RAM ports
    logic             pos_wr_en, pos_rd_en;
    logic [IB-1:0]    pos_wr_addr, pos_rd_addr;
    logic [POS_W-1:0] pos_wr_data, pos_rd_data;
    logic             mem_wr_en, mem_rd_en;
    logic [IB-1:0]    mem_wr_addr, mem_rd_addr;
    logic [MEM_W-1:0] mem_wr_data, mem_rd_data;

    logic                pos_vld;
    logic [IB-1:0]       pos_p;
    logic [IB-1:0]       mem_rd_idx;
    logic [GEN_BITS-1:0] mem_rd_gen;
    logic [IB:0]         last_pos;

    assign pos_vld    = pos_rd_data[IB];
    assign pos_p      = pos_rd_data[IB-1:0];
    assign mem_rd_idx = mem_rd_data[MEM_W-1:GEN_BITS];
    assign mem_rd_gen = mem_rd_data[GEN_BITS-1:0];
    assign last_pos   = count_reg - (IB+1)'(1);

    // position table: slot index -> {present, dense position}
    ssm_ram #(
        .ADDR_BITS (IB),
        .DATA_BITS (POS_W)
    ) u_pos_table (
        .aclk    (aclk),
        .wr_en   (pos_wr_en),
        .wr_addr (pos_wr_addr),
        .wr_data (pos_wr_data),
        .rd_en   (pos_rd_en),
        .rd_addr (pos_rd_addr),
        .rd_data (pos_rd_data)
    );

    // member array: dense position -> {slot index, generation}
    ssm_ram #(
        .ADDR_BITS (IB),
        .DATA_BITS (MEM_W)
    ) u_member_array (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        init_next    = init_reg;
        count_next   = count_reg;
        walk_next    = walk_reg;
        pend_next    = pend_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        gen_next     = gen_reg;
        dpos_next    = dpos_reg;
        p_next       = p_reg;
        hit_next     = hit_reg;
        slot_next    = slot_reg;
        eidx_next    = eidx_reg;
        egen_next    = egen_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_hit_next   = m_hit_reg;
        m_slot_next  = m_slot_reg;
        m_eidx_next  = m_eidx_reg;
        m_egen_next  = m_egen_reg;
        m_count_next = m_count_reg;

        pos_rd_en    = 1'b0;
        pos_rd_addr  = idx_reg;
        pos_wr_en    = 1'b0;
        pos_wr_addr  = idx_reg;
        pos_wr_data  = '0;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = last_pos[IB-1:0];
        mem_wr_en    = 1'b0;
        mem_wr_addr  = pos_p;
        mem_wr_data  = {idx_reg, gen_reg};

        unique case (state_reg)
            ST_INIT: begin
                // mark every slot absent
                pos_wr_en   = 1'b1;
                pos_wr_addr = init_reg;
                init_next   = init_reg + IB'(1);
                if (&init_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = op_t'(s_op);
                    idx_next   = s_entity_index;
                    gen_next   = s_entity_generation;
                    dpos_next  = s_dense_position;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                hit_next  = 1'b0;
                slot_next = '0;
                eidx_next = '0;
                egen_next = '0;
                walk_next = '0;
                pend_next = 1'b0;
                pos_rd_en = 1'b1;
                mem_rd_en = 1'b1;
                // read wants the addressed entry; erase wants the last one
                if (op_reg == OP_READ) begin
                    mem_rd_addr = dpos_reg;
                end
                state_next = (op_reg == OP_CLEAR) ? ST_CLR : ST_EVAL;
            end
            ST_EVAL: begin
                state_next = ST_DONE;
                unique case (op_reg)
                    OP_INSERT: begin
                        if (pos_vld) begin
                            // present: overwrite generation in place
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = pos_p;
                            hit_next    = 1'b1;
                            slot_next   = pos_p;
                        end else if (!count_reg[IB]) begin
                            pos_wr_en   = 1'b1;
                            pos_wr_addr = idx_reg;
                            pos_wr_data = {1'b1, count_reg[IB-1:0]};
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = count_reg[IB-1:0];
                            slot_next   = count_reg[IB-1:0];
                            count_next  = count_reg + (IB+1)'(1);
                        end
                    end
                    OP_ERASE: begin
                        if (pos_vld && (count_reg != '0)) begin
                            // move last entry into the freed position
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = pos_p;
                            mem_wr_data = mem_rd_data;
                            pos_wr_en   = 1'b1;
                            pos_wr_addr = mem_rd_idx;
                            pos_wr_data = {1'b1, pos_p};
                            count_next  = last_pos;
                            hit_next    = 1'b1;
                            slot_next   = pos_p;
                            state_next  = ST_ERASE2;
                        end
                    end
                    OP_CONTAINS: begin
                        if (pos_vld) begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = pos_p;
                            p_next      = pos_p;
                            state_next  = ST_CHECK;
                        end
                    end
                    OP_READ: begin
                        if ({1'b0, dpos_reg} < count_reg) begin
                            hit_next  = 1'b1;
                            slot_next = dpos_reg;
                            eidx_next = mem_rd_idx;
                            egen_next = mem_rd_gen;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_CHECK: begin
                if (({1'b0, p_reg} < count_reg) && (mem_rd_idx == idx_reg)
                        && (mem_rd_gen == gen_reg)) begin
                    hit_next  = 1'b1;
                    slot_next = p_reg;
                end
                state_next = ST_DONE;
            end
            ST_ERASE2: begin
                // drop the erased slot; after the move so it wins when
                // the erased entry was the last one
                pos_wr_en   = 1'b1;
                pos_wr_addr = idx_reg;
                pos_wr_data = '0;
                state_next  = ST_DONE;
            end
            ST_CLR: begin
                // pipelined walk: read member k, clear its slot next cycle
                if (pend_reg) begin
                    pos_wr_en   = 1'b1;
                    pos_wr_addr = mem_rd_idx;
                    pos_wr_data = '0;
                end
                if (walk_reg < count_reg) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = walk_reg[IB-1:0];
                    walk_next   = walk_reg + (IB+1)'(1);
                    pend_next   = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = hit_reg;
                    m_slot_next  = slot_reg;
                    m_eidx_next  = eidx_reg;
                    m_egen_next  = egen_reg;
                    m_count_next = count_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            init_reg    <= '0;
            count_reg   <= '0;
            walk_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            count_reg   <= count_next;
            walk_reg    <= walk_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        gen_reg     <= gen_next;
        dpos_reg    <= dpos_next;
        p_reg       <= p_next;
        hit_reg     <= hit_next;
        slot_reg    <= slot_next;
        eidx_reg    <= eidx_next;
        egen_reg    <= egen_next;
        m_hit_reg   <= m_hit_next;
        m_slot_reg  <= m_slot_next;
        m_eidx_reg  <= m_eidx_next;
        m_egen_reg  <= m_egen_next;
        m_count_reg <= m_count_next;
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_hit              = m_hit_reg;
    assign m_slot_position    = m_slot_reg;
    assign m_entry_index      = m_eidx_reg;
    assign m_entry_generation = m_egen_reg;
    assign m_member_count     = m_count_reg;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sparse set membership block. Requests go in on
// a valid/ready channel with random idle gaps and results are drained with
// random back-pressure. A shadow copy of the set, kept in a scoreboard class,
// predicts each result when its request is accepted. Every result is then
// compared field by field, in order. Stimulus covers a directed opening, a
// full fill to capacity, and mixed random traffic over small index pools.
// ----------------------------------------------------------------------------
module tb_top
    import ssm_pkg::*;
();

    localparam int IDX_W         = 10;
    localparam int GEN_W         = 16;
    localparam int CAPACITY      = 1 << IDX_W;
    localparam int GEN_MAX       = (1 << GEN_W) - 1;
    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 9;
    localparam int TAIL_CYCLES   = 24;
    // The limit allows for long gaps on both sides of every request, a few
    // clears over a full set, and the table sweep after reset.
    localparam int LIMIT_CYCLES  = 1_500_000;

    // Op codes the block does not define; they must leave the set untouched.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID   = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    typedef struct {
        logic             hit;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
        logic [IDX_W:0]   count;
    } membership_outcome_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow set plus the queue of outcomes still owed by the DUT.
    // ------------------------------------------------------------------------
    class membership_scoreboard;
        bit               present [CAPACITY];
        bit [IDX_W-1:0]   where   [CAPACITY];
        bit [IDX_W-1:0]   mem_idx [CAPACITY];
        bit [GEN_W-1:0]   mem_gen [CAPACITY];
        int               members;
        int               errors;
        membership_outcome_t awaited_outcomes [$];

        function int pending();
            return awaited_outcomes.size();
        endfunction

        // Apply one accepted request to the shadow set and queue its outcome.
        function void note_request(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                                   input logic [GEN_W-1:0] gen,
                                   input logic [IDX_W-1:0] dpos);
            membership_outcome_t o;
            bit [IDX_W-1:0]      p;
            bit [IDX_W-1:0]      last;
            bit [IDX_W-1:0]      moved;
            o = '{hit: 1'b0, slot: '0, idx: '0, gen: '0, count: '0};
            case (op)
                OP_INSERT: begin
                    if (present[idx]) begin
                        // already a member: new generation in place
                        p          = where[idx];
                        mem_gen[p] = gen;
                        mem_idx[p] = idx;
                        o.hit      = 1'b1;
                        o.slot     = p;
                    end else if (members < CAPACITY) begin
                        present[idx]     = 1'b1;
                        where[idx]       = IDX_W'(members);
                        mem_idx[members] = idx;
                        mem_gen[members] = gen;
                        o.slot           = IDX_W'(members);
                        members++;
                    end
                end
                OP_ERASE: begin
                    if (present[idx] && members > 0) begin
                        // last dense entry fills the hole
                        p            = where[idx];
                        last         = IDX_W'(members - 1);
                        moved        = mem_idx[last];
                        mem_idx[p]   = moved;
                        mem_gen[p]   = mem_gen[last];
                        where[moved] = p;
                        members--;
                        present[idx] = 1'b0;
                        o.hit        = 1'b1;
                        o.slot       = p;
                    end
                end
                OP_CONTAINS: begin
                    if (present[idx]) begin
                        p = where[idx];
                        if (p < members && mem_idx[p] == idx && mem_gen[p] == gen) begin
                            o.hit  = 1'b1;
                            o.slot = p;
                        end
                    end
                end
                OP_CLEAR: begin
                    for (int k = 0; k < members; k++)
                        present[mem_idx[k]] = 1'b0;
                    members = 0;
                end
                OP_READ: begin
                    if (dpos < members) begin
                        o.hit  = 1'b1;
                        o.slot = dpos;
                        o.idx  = mem_idx[dpos];
                        o.gen  = mem_gen[dpos];
                    end
                end
                default: ;
            endcase
            o.count = (IDX_W + 1)'(members);
            awaited_outcomes = {awaited_outcomes, o};
        endfunction

        function void check_result(input membership_outcome_t got);
            membership_outcome_t want;
            if (awaited_outcomes.size() == 0) begin
                $display("%0t: unexpected result, hit %0d slot %0d count %0d",
                         $time, got.hit, got.slot, got.count);
                errors++;
                return;
            end
            want = awaited_outcomes.pop_front();
            if (got.hit !== want.hit) begin
                $display("%0t: hit expected %0d, got %0d", $time, want.hit, got.hit);
                errors++;
            end
            if (got.slot !== want.slot) begin
                $display("%0t: slot_position expected %0d, got %0d",
                         $time, want.slot, got.slot);
                errors++;
            end
            if (got.idx !== want.idx) begin
                $display("%0t: entry_index expected %0d, got %0d", $time, want.idx, got.idx);
                errors++;
            end
            if (got.gen !== want.gen) begin
                $display("%0t: entry_generation expected %0h, got %0h",
                         $time, want.gen, got.gen);
                errors++;
            end
            if (got.count !== want.count) begin
                $display("%0t: member_count expected %0d, got %0d",
                         $time, want.count, got.count);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT, shared state
    // ------------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn;

    logic             s_valid;
    logic             s_ready;
    logic [2:0]       s_op;
    logic [IDX_W-1:0] s_entity_index;
    logic [GEN_W-1:0] s_entity_generation;
    logic [IDX_W-1:0] s_dense_position;

    logic             m_valid;
    logic             m_ready;
    logic             m_hit;
    logic [IDX_W-1:0] m_slot_position;
    logic [IDX_W-1:0] m_entry_index;
    logic [GEN_W-1:0] m_entry_generation;
    logic [IDX_W:0]   m_member_count;

    membership_scoreboard sb = new();
    membership_outcome_t  seen;

    // When set, neither side idles: back-to-back stretches.
    bit calm;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    sparse_set_membership #(
        .INDEX_BITS (IDX_W),
        .GEN_BITS   (GEN_W)
    ) i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_op                (s_op),
        .s_entity_index      (s_entity_index),
        .s_entity_generation (s_entity_generation),
        .s_dense_position    (s_dense_position),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_hit               (m_hit),
        .m_slot_position     (m_slot_position),
        .m_entry_index       (m_entry_index),
        .m_entry_generation  (m_entry_generation),
        .m_member_count      (m_member_count)
    );

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90)         return $urandom_range(1, 3);
        if (r < 97)         return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Called at a rising edge; returns at the edge that takes
    // the request. Handshake is sampled at the falling edge, where every
    // signal is settled, so there is no race with the DUT's own flops.
    // ------------------------------------------------------------------------
    task automatic issue_request(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                                 input logic [GEN_W-1:0] gen,
                                 input logic [IDX_W-1:0] dpos);
        int idle;
        bit taken;
        idle = pick_idle_cycles();
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_op                <= op;
        s_entity_index      <= idx;
        s_entity_generation <= gen;
        s_dense_position    <= dpos;
        do begin
            @(negedge aclk);
            taken = (s_ready === 1'b1);
            if (taken) sb.note_request(op, idx, gen, dpos);
            @(posedge aclk);
        end while (!taken);
    endtask

    // Sender holds off until every outstanding result is back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Mixed random traffic over a small pool of indices so that inserts,
    // erases and lookups keep running into each other. One in ten indices is
    // drawn from the whole range to keep misses and full-width values coming.
    // ------------------------------------------------------------------------
    task automatic run_mixed(input int n_items, input int pool_size);
        logic [IDX_W-1:0] pool [64];
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
        logic [IDX_W-1:0] dpos;
        logic [2:0]       op;
        int               pick;
        for (int k = 0; k < pool_size; k++)
            pool[k] = IDX_W'($urandom_range(0, CAPACITY - 1));
        for (int n = 0; n < n_items; n++) begin
            idx  = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, CAPACITY - 1))
                                                : pool[$urandom_range(0, pool_size - 1)];
            gen  = GEN_W'($urandom_range(0, GEN_MAX));
            dpos = IDX_W'($urandom_range(0, CAPACITY - 1));
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                op = OP_INSERT;
            end else if (pick < 55) begin
                op = OP_ERASE;
            end else if (pick < 75) begin
                op = OP_CONTAINS;
                // ask for the stored handle most of the time so hits are common
                if (sb.present[idx] && $urandom_range(0, 2) != 0)
                    gen = sb.mem_gen[sb.where[idx]];
            end else if (pick < 93) begin
                op = OP_READ;
                // iterate inside the set, including the first position past it
                if (pick < 88)
                    dpos = IDX_W'($urandom_range(0, sb.members));
            end else if (pick < 95) begin
                op = OP_CLEAR;
            end else begin
                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            end
            issue_request(op, idx, gen, dpos);
        end
    endtask

    // ------------------------------------------------------------------------
    // Fill every slot in shuffled order, poke at the full set, then clear it.
    // Dense order equals insert order, so order[] tells which index sits at
    // each dense position right after the fill.
    // ------------------------------------------------------------------------
    task automatic fill_to_capacity();
        logic [IDX_W-1:0] order [CAPACITY];
        logic [IDX_W-1:0] tmp;
        int               j;
        for (int k = 0; k < CAPACITY; k++) order[k] = IDX_W'(k);
        for (int k = CAPACITY - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        issue_request(OP_CLEAR, '0, '0, '0);
        for (int k = 0; k < CAPACITY; k++)
            issue_request(OP_INSERT, order[k], GEN_W'($urandom_range(0, GEN_MAX)), '0);
        // full set: top of the dense array, overwrite, lookups
        issue_request(OP_READ, '0, '0, IDX_W'(CAPACITY - 1));
        issue_request(OP_READ, '0, '0, '0);
        issue_request(OP_INSERT, order[0], '1, '0);
        issue_request(OP_CONTAINS, order[0], '1, '0);
        issue_request(OP_CONTAINS, order[CAPACITY - 1], '0, '0);
        // drop the last dense entry, refill, then erase from the front
        issue_request(OP_ERASE, order[CAPACITY - 1], '0, '0);
        issue_request(OP_READ, '0, '0, IDX_W'(CAPACITY - 1));
        issue_request(OP_INSERT, order[CAPACITY - 1], 16'h5A5A, '0);
        issue_request(OP_ERASE, order[0], '0, '0);
        issue_request(OP_READ, '0, '0, '0);
        issue_request(OP_CONTAINS, order[CAPACITY - 1], 16'h5A5A, '0);
        issue_request(OP_INSERT, order[0], 16'hA5A5, '0);
        issue_request(OP_READ, '0, '0, IDX_W'(CAPACITY - 1));
        issue_request(OP_SPARE_LAST, order[5], '1, '1);
        // clear walks all 1024 entries
        issue_request(OP_CLEAR, '0, '0, '0);
        issue_request(OP_CONTAINS, order[0], 16'hA5A5, '0);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, and the check of every taken result.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = pick_idle_cycles();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(negedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            seen.hit   = m_hit;
            seen.slot  = m_slot_position;
            seen.idx   = m_entry_index;
            seen.gen   = m_entry_generation;
            seen.count = m_member_count;
            sb.check_result(seen);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        calm                <= 1'b0;
        aresetn             <= 1'b0;
        s_valid             <= 1'b0;
        s_op                <= OP_INSERT;
        s_entity_index      <= '0;
        s_entity_generation <= '0;
        s_dense_position    <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening. The table sweep after reset holds s_ready low,
        // the driver simply waits it out.
        issue_request(OP_READ,     '0,       '0,       '0);     // empty set
        issue_request(OP_READ,     '0,       '0,       '1);
        issue_request(OP_CONTAINS, '0,       '0,       '0);     // absent
        issue_request(OP_ERASE,    '1,       '0,       '0);     // absent
        issue_request(OP_INSERT,   '0,       '0,       '0);
        issue_request(OP_INSERT,   '1,       '1,       '0);
        issue_request(OP_INSERT,   '0,       16'h1234, '0);     // present: overwrite
        issue_request(OP_CONTAINS, '0,       16'h1234, '0);
        issue_request(OP_CONTAINS, '0,       '0,       '0);     // stale generation
        issue_request(OP_CONTAINS, '1,       '1,       '0);
        issue_request(OP_READ,     '0,       '0,       10'd1);
        issue_request(OP_READ,     '0,       '0,       10'd2);  // one past the end
        issue_request(OP_ERASE,    '1,       '0,       '0);     // last dense entry
        issue_request(OP_INSERT,   10'h155,  16'hAAAA, '0);
        issue_request(OP_INSERT,   10'h2AA,  16'h5555, '0);
        issue_request(OP_ERASE,    '0,       '0,       '0);     // tail moves to front
        issue_request(OP_READ,     '0,       '0,       '0);
        issue_request(OP_SPARE_FIRST, 10'h2AA, 16'h5555, '1);
        issue_request(OP_SPARE_MID,   '1,      '1,       '0);
        issue_request(OP_SPARE_LAST,  '0,      '0,       '1);
        issue_request(OP_CLEAR,    '0,       '0,       '0);
        issue_request(OP_CONTAINS, 10'h2AA,  16'h5555, '0);     // gone after clear
        issue_request(OP_READ,     '0,       '0,       '0);
        issue_request(OP_CLEAR,    '0,       '0,       '0);     // clear of empty set
        issue_request(OP_INSERT,   10'h2AA,  16'h5555, '0);
        wait_drained();

        calm <= 1'b0;
        run_mixed(150, 8);
        calm <= 1'b1;
        run_mixed(150, 40);
        wait_drained();

        calm <= 1'b0;
        fill_to_capacity();
        wait_drained();

        run_mixed(120, 64);
        calm <= 1'b1;
        run_mixed(60, 4);
        calm <= 1'b0;
        run_mixed(60, 16);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS sparse_set_membership");
        else
            $display("FAIL sparse_set_membership");
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("FAIL sparse_set_membership");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ssm_pkg.sv
rtl/ssm_ram.sv
rtl/sparse_set_membership.sv
tb/tb_top.sv
